/* src/rgba_pixel_blend_unit_core_macros.svh */
// assertion macros for the pixel blend unit
`ifndef RGBA_PIXEL_BLEND_UNIT_CORE_MACROS_SVH
`define RGBA_PIXEL_BLEND_UNIT_CORE_MACROS_SVH

// condition holds at every clock edge outside reset
`define RPBU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent on the following edge
`define RPBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rpbu_pkg.sv */
`timescale 1ns / 1ps
package rpbu_pkg;

  typedef enum logic [2:0] {
    CMD_OVER   = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_SUB    = 3'd3,
    CMD_LERP   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_OVER,
    KIND_REMOVE
  } kind_e;

  localparam int unsigned NumCol = 3;
  localparam int unsigned NumDivStg = 4;
  localparam logic [15:0] RemoveDiv = 16'd65025;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
    logic [7:0] bottom_alpha;
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] top_alpha;
    logic [8:0] blend_weight;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  // products stage
  typedef struct packed {
    kind_e                    kind;
    pix_out_t                 fin;
    logic [7:0]               ab;
    logic [15:0]              m;
    logic [NumCol-1:0][15:0]  p_ta;
    logic [NumCol-1:0][15:0]  p_cb;
  } s1_t;

  // weighted terms stage
  typedef struct packed {
    kind_e                    kind;
    pix_out_t                 fin;
    logic [15:0]              big_a;
    logic [NumCol-1:0][23:0]  pos;
    logic [NumCol-1:0][23:0]  neg;
  } s2_t;

  // divider stage
  typedef struct packed {
    pix_out_t                 fin;
    logic                     use_fin;
    logic                     zero;
    logic [15:0]              d;
    logic [NumCol-1:0]        sat;
    logic [NumCol-1:0][24:0]  rem;
    logic [NumCol-1:0][7:0]   q;
  } div_t;

endpackage

/* src/rgba_pixel_blend_unit_core.sv */
`timescale 1ns / 1ps
// rgba pixel blend unit: combines a bottom and a top rgba8 pixel under one of five
// modes (over, remove top layer, saturating add, saturating subtract, q8 lerp) into
// one rgba8 pixel. one request per clock is taken in steady flow; every request
// passes through the eight register stages in order: products, weighted terms,
// dividend and divisor set-up, four restoring divider stages that resolve two
// quotient bits each, and the output register. each stage holds its own valid
// bit and stalls only when full and blocked downstream, so bubbles close up and
// the input keeps taking requests while a finished pixel waits on the output,
// until the stages behind it are full
module rgba_pixel_blend_unit_core import rpbu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pix_in_t  in_pix_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_pix_o
);

  localparam int unsigned NumStg = 4 + NumDivStg;

  // per-stage valid bits and advance enables
  logic [NumStg-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    for (int k = 0; k < NumStg; k++) begin
      if (en[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStg-1];

  // stage 1: channel products, simple modes finished here
  s1_t         s1_d, s1_q;
  logic [7:0]  cb [4];
  logic [7:0]  ct [4];
  logic [8:0]  w_eff;
  logic [8:0]  w_inv;
  logic [16:0] lerp_sum;
  logic [8:0]  add_sum;
  logic [7:0]  res [4];

  always_comb begin
    cb[0] = in_pix_i.bottom_red;
    cb[1] = in_pix_i.bottom_green;
    cb[2] = in_pix_i.bottom_blue;
    cb[3] = in_pix_i.bottom_alpha;
    ct[0] = in_pix_i.top_red;
    ct[1] = in_pix_i.top_green;
    ct[2] = in_pix_i.top_blue;
    ct[3] = in_pix_i.top_alpha;
    // weights above one saturate to fully top
    w_eff = in_pix_i.blend_weight[8] ? 9'd256 : in_pix_i.blend_weight;
    w_inv = 9'd256 - w_eff;
    lerp_sum = '0;
    add_sum  = '0;

    for (int i = 0; i < 4; i++) begin
      res[i] = cb[i];
    end

    case (in_pix_i.cmd)
      CMD_ADD: begin
        for (int i = 0; i < NumCol; i++) begin
          add_sum = {1'b0, cb[i]} + {1'b0, ct[i]};
          res[i]  = add_sum[8] ? 8'hff : add_sum[7:0];
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < NumCol; i++) begin
          res[i] = (cb[i] > ct[i]) ? cb[i] - ct[i] : 8'd0;
        end
      end
      CMD_LERP: begin
        for (int i = 0; i < 4; i++) begin
          lerp_sum = 17'(cb[i] * w_inv) + 17'(ct[i] * w_eff);
          res[i]   = lerp_sum[15:8];
        end
      end
      default: begin
      end
    endcase

    case (in_pix_i.cmd)
      CMD_OVER:   s1_d.kind = KIND_OVER;
      CMD_REMOVE: s1_d.kind = KIND_REMOVE;
      default:    s1_d.kind = KIND_PASS;
    endcase

    s1_d.fin = '{out_red: res[0], out_green: res[1], out_blue: res[2], out_alpha: res[3]};
    s1_d.ab  = cb[3];
    s1_d.m   = 16'((8'd255 - cb[3]) * ct[3]);
    for (int i = 0; i < NumCol; i++) begin
      s1_d.p_ta[i] = 16'(ct[i] * ct[3]);
      s1_d.p_cb[i] = 16'(cb[i] * (8'd255 - ct[3]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: bottom term times bottom alpha, top term times 255, combined alpha
  s2_t s2_d, s2_q;

  always_comb begin
    s2_d.kind  = s1_q.kind;
    s2_d.fin   = s1_q.fin;
    s2_d.big_a = 16'(s1_q.ab * 8'd255) + s1_q.m;
    for (int i = 0; i < NumCol; i++) begin
      s2_d.pos[i] = 24'(s1_q.p_cb[i] * s1_q.ab);
      s2_d.neg[i] = {s1_q.p_ta[i], 8'h00} - {8'h00, s1_q.p_ta[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: dividend, divisor, saturation check, alpha by reciprocal of 255
  div_t        dv_q [NumDivStg+1];
  div_t        dv_d [NumDivStg+1];
  logic [16:0] alpha_rc;
  logic        is_over;

  always_comb begin
    is_over  = (s2_q.kind == KIND_OVER);
    alpha_rc = {1'b0, s2_q.big_a} + 17'(s2_q.big_a[15:8]) + 17'd1;

    dv_d[0].fin     = s2_q.fin;
    dv_d[0].use_fin = (s2_q.kind == KIND_PASS);
    dv_d[0].zero    = is_over && (s2_q.big_a == '0);
    dv_d[0].d       = is_over ? s2_q.big_a : RemoveDiv;
    dv_d[0].q       = '0;
    if (is_over) begin
      dv_d[0].fin.out_alpha = dv_d[0].zero ? 8'd0 : alpha_rc[15:8];
    end
    for (int i = 0; i < NumCol; i++) begin
      if (is_over) begin
        dv_d[0].rem[i] = {1'b0, s2_q.pos[i]} + {1'b0, s2_q.neg[i]};
      end else begin
        dv_d[0].rem[i] = (s2_q.pos[i] > s2_q.neg[i]) ?
                         {1'b0, s2_q.pos[i] - s2_q.neg[i]} : 25'd0;
      end
      // quotient of 256 or more saturates
      dv_d[0].sat[i] = dv_d[0].rem[i] >= {1'b0, dv_d[0].d, 8'h00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dv_q[0] <= dv_d[0];
    end
  end

  // divider stages, two quotient bits each, msb first
  for (genvar g = 1; g <= NumDivStg; g++) begin : g_div
    localparam int unsigned BitHi = 9 - 2 * g;
    localparam int unsigned BitLo = 8 - 2 * g;

    logic [24:0] trial_hi, trial_lo;
    logic [24:0] rem_mid;

    always_comb begin
      dv_d[g]  = dv_q[g-1];
      trial_hi = {9'd0, dv_q[g-1].d} << BitHi;
      trial_lo = {9'd0, dv_q[g-1].d} << BitLo;
      rem_mid  = '0;
      for (int i = 0; i < NumCol; i++) begin
        rem_mid = dv_q[g-1].rem[i];
        if (rem_mid >= trial_hi) begin
          rem_mid               = rem_mid - trial_hi;
          dv_d[g].q[i][BitHi]   = 1'b1;
        end
        if (rem_mid >= trial_lo) begin
          rem_mid               = rem_mid - trial_lo;
          dv_d[g].q[i][BitLo]   = 1'b1;
        end
        dv_d[g].rem[i] = rem_mid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[2+g]) begin
        dv_q[g] <= dv_d[g];
      end
    end
  end

  // output register: pick finished pixel or quotients
  pix_out_t   out_d, out_q;
  logic [7:0] col [NumCol];

  always_comb begin
    for (int i = 0; i < NumCol; i++) begin
      if (dv_q[NumDivStg].zero) begin
        col[i] = 8'd0;
      end else if (dv_q[NumDivStg].sat[i]) begin
        col[i] = 8'hff;
      end else begin
        col[i] = dv_q[NumDivStg].q[i];
      end
    end
    out_d = dv_q[NumDivStg].fin;
    if (!dv_q[NumDivStg].use_fin) begin
      out_d.out_red   = col[0];
      out_d.out_green = col[1];
      out_d.out_blue  = col[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStg-1]) begin
      out_q <= out_d;
    end
  end

  assign out_pix_o = out_q;

endmodule

/* src/rpbu_checker.sv */
`timescale 1ns / 1ps
`include "rgba_pixel_blend_unit_core_macros.svh"
module rpbu_checker import rpbu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i
);

  localparam logic [3:0] MaxInFlight = 4'd8;

  logic       in_acc, out_acc;
  logic [3:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 4'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `RPBU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `RPBU_ASSERT(a_no_phantom, !out_valid_o || (cnt_q != 4'd0), "result with no request in flight")
  `RPBU_ASSERT(a_bounded, cnt_q <= MaxInFlight, "more requests in flight than stages")
  `RPBU_ASSERT(a_flow, !out_ready_i || in_ready_o, "input blocked while output drains")

endmodule

bind rgba_pixel_blend_unit_core rpbu_checker u_rpbu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);
